// ===== design/srsd_pkg.sv =====
// shared types and constants for the scaled rounded signed divider
// no dependencies

package srsd_pkg;

  localparam int unsigned MagBits  = 63;
  localparam int unsigned DivSteps = MagBits;
  localparam int unsigned Latency  = 4 + DivSteps;

  localparam logic [63:0] Si64Max = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

endpackage

// ===== design/scaled_rounded_signed_divider_unit.sv =====
// scaled rounded signed divider, 64-bit dividend by 32-bit divisor, fully pipelined
// depends on srsd_pkg (status codes, magnitude width, saturation value)

// A transaction is taken on every clock edge where start is high; busy is
// always low because the pipeline never stalls, and the receiver cannot hold
// results off, so nothing is buffered. Each result appears on quotient_o and
// status_o for one cycle with done_o high, in the order the transactions were
// taken. The pipeline is three front stages (magnitudes, power-of-two scaling,
// rounding add) plus 63 restoring divider stages, one quotient bit per stage,
// and a final sign and saturation register. A new transaction may enter every
// cycle.
module scaled_rounded_signed_divider_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] dividend_i,
  input  logic signed [6:0]  scale_shift_i,
  input  logic signed [31:0] divisor_i,
  output logic               done_o,
  output logic signed [63:0] quotient_o,
  output logic        [1:0]  status_o
);

  localparam int unsigned MB = srsd_pkg::MagBits;
  localparam int unsigned NS = srsd_pkg::DivSteps;

  assign busy = 1'b0;

  // stage 1: magnitudes and early status
  logic [63:0] ux_full;
  logic [31:0] uy_d;
  logic        vld1_q;
  logic [MB-1:0] ux1_q;
  logic [31:0] uy1_q;
  logic signed [6:0] sh1_q;
  logic        qneg1_q;
  srsd_pkg::status_e st1_d, st1_q;

  always_comb begin
    ux_full = dividend_i[63] ? (64'd0 - dividend_i) : dividend_i;
    uy_d    = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
    if (divisor_i == 32'sd0) begin
      st1_d = srsd_pkg::ST_DIV0;
    end else if (ux_full[63]) begin
      st1_d = srsd_pkg::ST_OVF;
    end else begin
      st1_d = srsd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    ux1_q   <= ux_full[MB-1:0];
    uy1_q   <= uy_d;
    sh1_q   <= scale_shift_i;
    qneg1_q <= dividend_i[63] ^ divisor_i[31];
    st1_q   <= st1_d;
  end

  // stage 2: power-of-two scaling with left overflow check
  logic [2*MB-1:0] wide_l;
  logic [6:0]      ramt;
  logic [MB-1:0]   sh2_d;
  logic            lovf;
  logic            vld2_q;
  logic [MB-1:0]   ux2_q;
  logic [31:0]     uy2_q;
  logic            qneg2_q;
  srsd_pkg::status_e st2_d, st2_q;

  always_comb begin
    wide_l = {{MB{1'b0}}, ux1_q} << sh1_q[5:0];
    ramt   = 7'd0 - sh1_q;
    lovf   = 1'b0;
    if (sh1_q > 7'sd0) begin
      sh2_d = wide_l[MB-1:0];
      lovf  = |wide_l[2*MB-1:MB];
    end else if (sh1_q < 7'sd0) begin
      sh2_d = ramt[6] ? '0 : (ux1_q >> ramt[5:0]);
    end else begin
      sh2_d = ux1_q;
    end
    st2_d = st1_q;
    if (st1_q == srsd_pkg::ST_OK && lovf) begin
      st2_d = srsd_pkg::ST_OVF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ux2_q   <= sh2_d;
    uy2_q   <= uy1_q;
    qneg2_q <= qneg1_q;
    st2_q   <= st2_d;
  end

  // stage 3: rounding add, feeds the divider chain
  logic [MB:0] rsum;
  srsd_pkg::status_e st3_d;

  logic              vld_q  [NS+1];
  logic [MB-1:0]     w_q    [NS+1];
  logic [31:0]       rem_q  [NS+1];
  logic [31:0]       uy_q   [NS+1];
  logic              qneg_q [NS+1];
  srsd_pkg::status_e st_q   [NS+1];

  always_comb begin
    rsum  = {1'b0, ux2_q} + {{(MB-30){1'b0}}, uy2_q[31:1]};
    st3_d = st2_q;
    if (st2_q == srsd_pkg::ST_OK && rsum[MB]) begin
      st3_d = srsd_pkg::ST_OVF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q[0]    <= rsum[MB-1:0];
    rem_q[0]  <= '0;
    uy_q[0]   <= uy2_q;
    qneg_q[0] <= qneg2_q;
    st_q[0]   <= st3_d;
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [32:0] trial;
    logic [32:0] diff;
    logic        take;

    always_comb begin
      trial = {rem_q[k], w_q[k][MB-1]};
      diff  = trial - {1'b0, uy_q[k]};
      take  = trial >= {1'b0, uy_q[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= take ? diff[31:0] : trial[31:0];
      w_q[k+1]    <= {w_q[k][MB-2:0], take};
      uy_q[k+1]   <= uy_q[k];
      qneg_q[k+1] <= qneg_q[k];
      st_q[k+1]   <= st_q[k];
    end
  end

  // output: sign, saturation and zero-divisor selection
  logic [63:0] qmag;
  logic [63:0] q_d;
  logic        done_q;
  logic [63:0] q_q;
  logic [1:0]  st_out_q;

  always_comb begin
    qmag = {1'b0, w_q[NS]};
    case (st_q[NS])
      srsd_pkg::ST_OK:   q_d = qneg_q[NS] ? (64'd0 - qmag) : qmag;
      srsd_pkg::ST_OVF:  q_d = qneg_q[NS] ? (64'd0 - srsd_pkg::Si64Max) : srsd_pkg::Si64Max;
      srsd_pkg::ST_DIV0: q_d = '0;
      default:           q_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    q_q      <= q_d;
    st_out_q <= st_q[NS];
  end

  assign done_o     = done_q;
  assign quotient_o = q_q;
  assign status_o   = st_out_q;

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(srsd_pkg::Latency) done_o)
    else $error("result did not arrive at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[NS]))
    else $error("result strobe without a transaction in flight");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == srsd_pkg::ST_DIV0) |-> (quotient_o == 64'sd0))
    else $error("divide by zero with nonzero quotient");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == srsd_pkg::ST_OVF) |->
      (quotient_o == srsd_pkg::Si64Max || quotient_o == (64'd0 - srsd_pkg::Si64Max)))
    else $error("overflow without saturated quotient");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == srsd_pkg::ST_OK || status_o == srsd_pkg::ST_OVF ||
                status_o == srsd_pkg::ST_DIV0))
    else $error("undefined status code");

endmodule

// ===== test/scaled_rounded_signed_divider_unit_tb.sv =====
// self-checking testbench for scaled_rounded_signed_divider_unit
// depends on srsd_pkg (status codes, latency, saturation value) and the unit itself
// directed edge cases, then random transactions with random start gaps

module scaled_rounded_signed_divider_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [63:0] dividend;
    logic signed [6:0]  shift;
    logic signed [31:0] divisor;
    logic               drain;
    logic               steady;
  } division_t;

  typedef struct {
    logic [63:0]       quotient;
    srsd_pkg::status_e status;
  } quotient_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [63:0] dividend_i = '0;
  logic signed [6:0]  scale_shift_i = '0;
  logic signed [31:0] divisor_i = '0;
  logic               done_o;
  logic signed [63:0] quotient_o;
  logic        [1:0]  status_o;

  division_t pending_divisions[$];
  quotient_t awaited_quotients[$];
  division_t next_div;
  quotient_t want;
  logic      taken = 1'b0;
  int        errors = 0;

  scaled_rounded_signed_divider_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .dividend_i   (dividend_i),
    .scale_shift_i(scale_shift_i),
    .divisor_i    (divisor_i),
    .done_o       (done_o),
    .quotient_o   (quotient_o),
    .status_o     (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic quotient_t predict_division(input logic signed [63:0] dvd,
                                                 input logic signed [6:0]  sh,
                                                 input logic signed [31:0] dvs);
    quotient_t   res;
    logic [63:0] mag;
    logic [63:0] dmag;
    logic [63:0] sat;
    logic        neg;
    int          s;
    res.quotient = '0;
    res.status   = srsd_pkg::ST_OK;
    if (dvs == 0) begin
      res.status = srsd_pkg::ST_DIV0;
      return res;
    end
    s   = int'(sh);
    neg = dvd[63] ^ dvs[31];
    sat = neg ? (64'd0 - srsd_pkg::Si64Max) : srsd_pkg::Si64Max;
    mag = dvd[63] ? (64'd0 - dvd) : dvd;
    res.quotient = sat;
    res.status   = srsd_pkg::ST_OVF;
    if (mag[63]) return res;
    if (s > 0) begin
      if ((mag >> (63 - s)) != 0) return res;
      mag = mag << s;
    end else if (s < 0) begin
      mag = (s <= -64) ? 64'd0 : (mag >> (-s));
    end
    dmag = dvs[31] ? ((64'h1_0000_0000 - {32'd0, dvs}) & 64'h1_FFFF_FFFF) : {32'd0, dvs};
    mag  = mag + (dmag >> 1);
    if (mag > srsd_pkg::Si64Max) return res;
    mag = mag / dmag;
    res.quotient = neg ? (64'd0 - mag) : mag;
    res.status   = srsd_pkg::ST_OK;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic add_division(input logic signed [63:0] dvd, input logic signed [6:0] sh,
                              input logic signed [31:0] dvs, input logic drain = 1'b0,
                              input logic steady = 1'b0);
    division_t d;
    d.dividend = dvd;
    d.shift    = sh;
    d.divisor  = dvs;
    d.drain    = drain;
    d.steady   = steady;
    pending_divisions.push_back(d);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pending_divisions.size() != 0 &&
          !(pending_divisions[0].drain && awaited_quotients.size() != 0) &&
          (pending_divisions[0].steady || $urandom_range(99) >= 18)) begin
        next_div      = pending_divisions.pop_front();
        dividend_i    <= next_div.dividend;
        scale_shift_i <= next_div.shift;
        divisor_i     <= next_div.divisor;
        start         <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    taken <= rst_ni && start && !busy;
    if (rst_ni && start && !busy)
      awaited_quotients.push_back(predict_division(dividend_i, scale_shift_i, divisor_i));
    if (rst_ni && done_o) begin
      if (awaited_quotients.size() == 0) begin
        report_mismatch($sformatf("unexpected result quotient %h status %0d",
                                  quotient_o, status_o));
      end else begin
        want = awaited_quotients.pop_front();
        if (quotient_o !== want.quotient)
          report_mismatch($sformatf("quotient %h, expected %h", quotient_o, want.quotient));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
      end
    end
  end

  initial begin
    logic signed [63:0] dvd;
    logic signed [6:0]  sh;
    logic signed [31:0] dvs;
    int                 mode;

    // divide by zero, also for the most negative dividend
    add_division(64'sh8000_0000_0000_0000, 7'sd0, 32'sd0);
    add_division(64'sd12345, 7'sd3, 32'sd0);
    // most negative dividend always saturates
    add_division(64'sh8000_0000_0000_0000, -7'sd10, 32'sd1);
    add_division(64'sh8000_0000_0000_0000, 7'sd0, -32'sd1);
    // largest dividend, rounding overflow
    add_division(64'sh7FFF_FFFF_FFFF_FFFF, 7'sd0, 32'sd1);
    add_division(64'sh7FFF_FFFF_FFFF_FFFF, 7'sd0, 32'sd2);
    add_division(64'sh7FFF_FFFF_FFFF_FFFF, 7'sd0, -32'sd1);
    add_division(-64'sh7FFF_FFFF_FFFF_FFFF, 7'sd0, 32'sh7FFF_FFFF);
    // left shift limits
    add_division(64'sd1, 7'sd63, 32'sd1);
    add_division(64'sd0, 7'sd63, 32'sd5);
    add_division(64'sd1, 7'sd62, 32'sd1);
    add_division(64'sh4000_0000_0000_0000, 7'sd1, 32'sd3);
    add_division(64'sh3FFF_FFFF_FFFF_FFFF, 7'sd1, 32'sd3);
    // right shift limits, shift of -64
    add_division(64'sh7FFF_FFFF_FFFF_FFFF, 7'sh40, 32'sd1);
    add_division(64'sh7FFF_FFFF_FFFF_FFFF, -7'sd63, 32'sd1);
    add_division(-64'sd1000, -7'sd1, 32'sd7);
    // most negative divisor and largest divisor
    add_division(64'sh0123_4567_89AB_CDEF, 7'sd0, 32'sh8000_0000);
    add_division(-64'sh0123_4567_89AB_CDEF, 7'sd4, 32'sh8000_0000);
    add_division(64'sh7654_3210_FEDC_BA98, -7'sd2, 32'sh7FFF_FFFF);
    // zero magnitude with a negative sign
    add_division(-64'sd1, -7'sd5, 32'sd3);
    add_division(64'sd1, 7'sd0, -32'sd3);
    // rounding halfway
    add_division(64'sd7, 7'sd0, 32'sd2);
    add_division(-64'sd7, 7'sd0, 32'sd2);
    add_division(64'sd7, 7'sd0, -32'sd2);

    for (int i = 0; i < 400; i++) begin
      mode = $urandom_range(3);
      dvd  = {$urandom, $urandom};
      case (mode)
        1: begin
          dvd = dvd >>> $urandom_range(63);
        end
        2: begin
          dvd = $signed(64'($urandom_range(4095))) * ($urandom_range(1) ? -1 : 1);
        end
        3: begin
          case ($urandom_range(3))
            0: dvd = 64'sh8000_0000_0000_0000;
            1: dvd = 64'sh7FFF_FFFF_FFFF_FFFF;
            2: dvd = 64'sd0;
            default: dvd = -64'sd1;
          endcase
        end
        default: ;
      endcase
      if ($urandom_range(1))
        sh = 7'($urandom);
      else
        sh = 7'($signed($urandom_range(16)) - 8);
      case ($urandom_range(9))
        0: dvs = 32'sd0;
        1: dvs = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        2, 3: dvs = $signed(32'($urandom_range(16, 1))) * ($urandom_range(1) ? -1 : 1);
        default: dvs = $urandom;
      endcase
      add_division(dvd, sh, dvs, (i == 0 || i == 200 || i == 330), (i >= 100 && i < 200));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_divisions.size() != 0 || start) @(posedge clk_i);
    while (awaited_quotients.size() != 0) @(posedge clk_i);
    repeat (srsd_pkg::Latency + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("** scaled_rounded_signed_divider_unit: PASSED **");
    end else begin
      $display("** scaled_rounded_signed_divider_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** scaled_rounded_signed_divider_unit: FAILED **");
    $finish;
  end

endmodule
